FILE: src/khpe_pkg.sv
package khpe_pkg;

	localparam int NUM_BUTTONS = 5;
	localparam int CNT_W = 10;
	localparam int BYTE_W = 8;
	localparam int REP_W = 4;
	localparam int IDX_W = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [REP_W-1:0] MAX_REPEAT = 4'd12;
	localparam logic [BYTE_W-1:0] DATA_CNT_RESET = 8'h90;

	// register reset values
	localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;
	localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h44;
	localparam logic [CNT_W-1:0] THR_RESET = 10'd400;
	localparam logic [CNT_W-1:0] CEIL_RESET = 10'd1000;
	localparam logic [CNT_W-1:0] FOLD_RESET = 10'd500;
	localparam logic [REP_W-1:0] REPEAT_RESET = 4'd10;

	typedef enum logic [IDX_W-1:0] {
		REG_SYNC,
		REG_ADDR,
		REG_THR,
		REG_CEIL,
		REG_FOLD,
		REG_REPEAT
	} reg_idx_t;

	// settings seen by the lanes (threshold already forced to at least one)
	typedef struct packed {
		logic [CNT_W-1:0] thr;
		logic [CNT_W-1:0] ceil;
		logic [CNT_W-1:0] fold;
	} lane_cfg_t;

	// what one lane found for the current tick
	typedef struct packed {
		logic fire;
		logic [BYTE_W-1:0] code;
	} burst_t;

	function automatic logic [BYTE_W-1:0] on_code(input int idx);
		logic [BYTE_W-1:0] c;
		case (idx)
			0: c = 8'h11;
			1: c = 8'h22;
			2: c = 8'h66;
			3: c = 8'h77;
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] off_code(input int idx);
		logic [BYTE_W-1:0] c;
		case (idx)
			0: c = 8'h33;
			1: c = 8'h55;
			2: c = 8'h88;
			3: c = 8'h99;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

FILE: src/khpe_lane.sv
module khpe_lane (
	input  logic clk,
	input  logic arst_n,
	input  logic tick,
	input  logic held,
	input  khpe_pkg::lane_cfg_t cfg,
	input  logic [khpe_pkg::BYTE_W-1:0] on_c,
	input  logic [khpe_pkg::BYTE_W-1:0] off_c,
	output khpe_pkg::burst_t burst
);
	import khpe_pkg::*;

	logic [CNT_W-1:0] hold_count_q;
	logic on_flag_q;

	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] cnt_new;
	logic over;
	logic send_on;
	logic send_off;

	// advance the hold counter and decide on a burst
	always_comb begin
		cnt_inc = (hold_count_q >= cfg.ceil) ? cfg.fold : hold_count_q + 1'b1;
		cnt_new = held ? cnt_inc : hold_count_q;
		over = cnt_new >= cfg.thr;
		send_on = over && held;
		send_off = on_flag_q && ((cnt_new == '0) || (over && !held));
		burst.fire = send_on || send_off;
		burst.code = send_on ? on_c : off_c;
	end

	// commit lane state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_count_q <= '0;
			on_flag_q <= 1'b0;
		end else if (tick) begin
			hold_count_q <= (over && !held) ? '0 : cnt_new;
			if (send_on)
				on_flag_q <= 1'b1;
			else if (send_off)
				on_flag_q <= 1'b0;
		end
	end

endmodule

FILE: src/khpe_burst_seq.sv
module khpe_burst_seq (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic tick,
	input  khpe_pkg::burst_t [khpe_pkg::NUM_BUTTONS-1:0] bursts,
	input  logic [khpe_pkg::BYTE_W-1:0] sync_byte,
	input  logic [khpe_pkg::BYTE_W-1:0] rx_addr,
	input  logic [khpe_pkg::REP_W-1:0] reps,
	output logic out_valid,
	input  logic out_stall,
	output logic [khpe_pkg::BYTE_W-1:0] sync,
	output logic [khpe_pkg::BYTE_W-1:0] address,
	output logic [khpe_pkg::BYTE_W-1:0] command,
	output logic [khpe_pkg::BYTE_W-1:0] checksum,
	output logic last
);
	import khpe_pkg::*;

	logic [NUM_BUTTONS-1:0] mask_q;
	logic [NUM_BUTTONS-1:0][BYTE_W-1:0] codes_q;
	logic [REP_W-1:0] rep_q;

	logic out_valid_q;
	logic [BYTE_W-1:0] sync_q;
	logic [BYTE_W-1:0] address_q;
	logic [BYTE_W-1:0] command_q;
	logic [BYTE_W-1:0] checksum_q;
	logic last_q;

	logic busy;
	logic slot;
	logic emit;
	logic [NUM_BUTTONS-1:0] sel;
	logic [NUM_BUTTONS-1:0] rest;
	logic [NUM_BUTTONS-1:0] fire_mask;
	logic [BYTE_W-1:0] cur_code;
	logic rep_last;
	logic pkt_last;
	logic done_now;

	// pick the lowest pending button and the packet it sends
	always_comb begin
		busy = |mask_q;
		slot = !out_valid_q || !out_stall;
		emit = busy && slot;
		sel = mask_q & (~mask_q + 1'b1);
		rest = mask_q & ~sel;
		cur_code = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (sel[i])
				cur_code = cur_code | codes_q[i];
			fire_mask[i] = bursts[i].fire;
		end
		rep_last = rep_q == (reps - 1'b1);
		pkt_last = rep_last && (rest == '0);
		done_now = emit && pkt_last;
		in_stall = busy && !done_now;
		tick = in_valid && !in_stall;
	end

	// hold the job of the current tick and walk its packets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			rep_q <= '0;
		end else if (tick) begin
			mask_q <= (reps == '0) ? '0 : fire_mask;
			rep_q <= '0;
		end else if (emit) begin
			if (rep_last) begin
				mask_q <= rest;
				rep_q <= '0;
			end else begin
				rep_q <= rep_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			for (int i = 0; i < NUM_BUTTONS; i++)
				codes_q[i] <= bursts[i].code;
		end
	end

	// output register: one beat per cycle while not stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (slot)
			out_valid_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			sync_q <= sync_byte;
			address_q <= rx_addr;
			command_q <= cur_code;
			checksum_q <= rx_addr + cur_code;
			last_q <= pkt_last;
		end
	end

	assign out_valid = out_valid_q;
	assign sync = sync_q;
	assign address = address_q;
	assign command = command_q;
	assign checksum = checksum_q;
	assign last = last_q;

	// the repeat counter stays inside the burst length while a job runs
	a_rep_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> rep_q < reps)
		else $error("repeat counter past burst length");

	// the final packet of a tick empties the job unless a new tick loads
	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && pkt_last && !tick) |=> mask_q == '0)
		else $error("job left pending after last packet");

	// an idle sequencer never holds off the input
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !in_stall)
		else $error("input stalled while idle");

	// a new job starts at its first repeat
	a_load_rep: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> rep_q == '0)
		else $error("repeat counter not cleared on load");

endmodule

FILE: src/keypad_hold_to_packet_encoder_core.sv
// Keypad hold-to-packet encoder.
// Input channel (in_valid / in_stall / buttons_held): one beat per scan tick,
// bit i set means button i+1 is held. Five button lanes update their hold
// counters and on flags in the accept cycle; a sequencer then sends, for each
// button that fires, lowest button first, repeat_count packets of
// sync, address, command, checksum.
// Output channel (out_valid / out_stall): one packet per beat; last marks the
// final packet of a tick. A tick that sends nothing produces no beat.
// The first packet of a tick passes the job registers, loaded on acceptance,
// and then the output register.
// Throughput: one packet per cycle while out_stall is low, through the single
// output register. The next tick is accepted in the cycle its predecessor's
// last packet enters the output register.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
// always high; write only while idle. Indexes above five are ignored.
// Reset: lanes clear, data counter loads 0x90, registers take their defaults,
// no beat is pending. While out_stall is high a pending output beat holds and the
// sequencer waits, stalling the input once a job is pending.
module keypad_hold_to_packet_encoder_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [khpe_pkg::NUM_BUTTONS-1:0] buttons_held,
	output logic out_valid,
	input  logic out_stall,
	output logic [khpe_pkg::BYTE_W-1:0] sync,
	output logic [khpe_pkg::BYTE_W-1:0] address,
	output logic [khpe_pkg::BYTE_W-1:0] command,
	output logic [khpe_pkg::BYTE_W-1:0] checksum,
	output logic last,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [khpe_pkg::IDX_W-1:0] cfg_index,
	input  logic [khpe_pkg::CFG_DATA_W-1:0] cfg_data
);
	import khpe_pkg::*;

	logic [BYTE_W-1:0] sync_byte_q;
	logic [BYTE_W-1:0] rx_addr_q;
	logic [CNT_W-1:0] thr_q;
	logic [CNT_W-1:0] ceil_q;
	logic [CNT_W-1:0] fold_q;
	logic [REP_W-1:0] repeat_q;
	logic [BYTE_W-1:0] data_cnt_q;

	lane_cfg_t lane_cfg;
	logic [REP_W-1:0] reps_eff;
	logic tick;
	burst_t [NUM_BUTTONS-1:0] bursts;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_byte_q <= SYNC_RESET;
			rx_addr_q <= ADDR_RESET;
			thr_q <= THR_RESET;
			ceil_q <= CEIL_RESET;
			fold_q <= FOLD_RESET;
			repeat_q <= REPEAT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SYNC: sync_byte_q <= cfg_data[BYTE_W-1:0];
				REG_ADDR: rx_addr_q <= cfg_data[BYTE_W-1:0];
				REG_THR: thr_q <= cfg_data[CNT_W-1:0];
				REG_CEIL: ceil_q <= cfg_data[CNT_W-1:0];
				REG_FOLD: fold_q <= cfg_data[CNT_W-1:0];
				REG_REPEAT: repeat_q <= cfg_data[REP_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp threshold and repeat count
	always_comb begin
		lane_cfg.thr = (thr_q == '0) ? CNT_W'(1) : thr_q;
		lane_cfg.ceil = ceil_q;
		lane_cfg.fold = fold_q;
		reps_eff = (repeat_q > MAX_REPEAT) ? MAX_REPEAT : repeat_q;
	end

	// advance the data counter once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			data_cnt_q <= DATA_CNT_RESET;
		else if (tick)
			data_cnt_q <= data_cnt_q + 1'b1;
	end

	for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
		logic [BYTE_W-1:0] on_c;
		logic [BYTE_W-1:0] off_c;

		assign on_c = (g == 4) ? data_cnt_q : on_code(g);
		assign off_c = (g == 4) ? data_cnt_q : off_code(g);

		khpe_lane u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.tick  (tick),
			.held  (buttons_held[g]),
			.cfg   (lane_cfg),
			.on_c  (on_c),
			.off_c (off_c),
			.burst (bursts[g])
		);
	end

	khpe_burst_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.tick     (tick),
		.bursts   (bursts),
		.sync_byte(sync_byte_q),
		.rx_addr  (rx_addr_q),
		.reps     (reps_eff),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sync     (sync),
		.address  (address),
		.command  (command),
		.checksum (checksum),
		.last     (last)
	);

endmodule
